// ----- rtl/core/stm_pkg.sv -----
package stm_pkg;

    localparam int COORD_W    = 12;
    localparam int SIDE_W     = 13;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = SIDE_W + FRAC_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // floor(p / 255) as (p * RECIP) >> SHIFT, low by at most one for p < 2^21
    localparam int DIV_SHIFT = 29;
    localparam int RECIP_W   = 22;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd255);
    localparam int MUL_W     = PROD_W + RECIP_W;
    localparam logic [PROD_W-1:0] DIVISOR = PROD_W'(255);
    localparam logic [FRAC_W-1:0] FRAC_FULL = 8'hFF;

    typedef enum logic [1:0] {
        DIR_TOP_BOTTOM = 2'd0,
        DIR_BOTTOM_TOP = 2'd1,
        DIR_LEFT_RIGHT = 2'd2,
        DIR_RIGHT_LEFT = 2'd3
    } stm_dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIRECTION    = 3'd0,
        CFG_AMOUNT       = 3'd1,
        CFG_FRAME_WIDTH  = 3'd2,
        CFG_FRAME_HEIGHT = 3'd3,
        CFG_SLIDE_LOWER  = 3'd4,
        CFG_SLIDE_UPPER  = 3'd5
    } stm_cfg_idx_t;

    localparam logic [SIDE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIDE_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic load_mul;
        logic load_fix;
    } stm_div_ctrl_t;

endpackage

// ----- rtl/core/stm_channels.sv -----
interface stm_pixel_if;
    import stm_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface stm_result_if;
    import stm_pkg::*;
    logic               valid;
    logic               ready;
    logic               from_second;
    logic [COORD_W-1:0] source_x;
    logic [COORD_W-1:0] source_y;
    modport source (output valid, output from_second, output source_x, output source_y,
                    input ready);
    modport sink (input valid, input from_second, input source_x, input source_y,
                  output ready);
endinterface

// ----- rtl/core/stm_div255.sv -----
module stm_div255 (
    input  logic                          clk,
    input  stm_pkg::stm_div_ctrl_t        ctrl,
    input  logic [stm_pkg::PROD_W-1:0]    dividend,
    output logic [stm_pkg::SIDE_W-1:0]    quotient
);
    import stm_pkg::*;

    logic [PROD_W-1:0] dividend_reg;
    logic [MUL_W-1:0]  mul_reg;
    logic [MUL_W-1:0]  mul_next;
    logic [SIDE_W-1:0] quot_reg;
    logic [SIDE_W-1:0] quot_next;
    logic [SIDE_W-1:0] q_est;
    logic [PROD_W-1:0] rem;

    // reciprocal multiply
    assign mul_next = MUL_W'(dividend) * MUL_W'(DIV_RECIP);

    // estimate is exact or one low: fix with one compare
    assign q_est     = mul_reg[DIV_SHIFT +: SIDE_W];
    assign rem       = dividend_reg - (PROD_W'({q_est, 8'd0}) - PROD_W'(q_est));
    assign quot_next = (rem >= DIVISOR) ? q_est + SIDE_W'(1) : q_est;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            dividend_reg <= dividend;
            mul_reg      <= mul_next;
        end
        if (ctrl.load_fix)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;

endmodule

// ----- rtl/core/slide_transition_source_mapper_core.sv -----
// Slide-over transition source mapper. For each output pixel (pixel_x,
// pixel_y) the block returns which frame supplies it (from_second) and the
// column and row to read there. The moving bound is floor(side*frac/255),
// with side the clamped frame height or width and frac the amount or
// 255 minus it, depending on direction. The datapath is a four-stage
// pipeline: side*frac multiply, reciprocal multiply by 1/255, one-step
// remainder correction, then the compare and offset into the output
// register. One item enters every clock while the output does not stall;
// a result waits in the output register until it is taken. A stalled output
// holds the whole pipeline in place, while empty stages keep filling, so
// nothing is lost or repeated. No clearing pass follows reset. Write
// configuration only while the pipeline is empty; writes to indexes outside
// the register list are dropped.
module slide_transition_source_mapper_core #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stm_pkg::CFG_DATA_W-1:0]     cfg_data,
    stm_pixel_if.sink                          pixel,
    stm_result_if.source                       result
);
    import stm_pkg::*;

    localparam logic [31:0] MAX_SIDE = 32'(MAX_FRAME_SIDE);

    // configuration registers
    logic [1:0]        direction_reg;
    logic [FRAC_W-1:0] amount_reg;
    logic [SIDE_W-1:0] frame_width_reg;
    logic [SIDE_W-1:0] frame_height_reg;
    logic              slide_lower_reg;
    logic              slide_upper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= DIR_TOP_BOTTOM;
            amount_reg       <= '0;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            slide_lower_reg  <= 1'b1;
            slide_upper_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION:    direction_reg    <= cfg_data[1:0];
                CFG_AMOUNT:       amount_reg       <= cfg_data[FRAC_W-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIDE_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIDE_W-1:0];
                CFG_SLIDE_LOWER:  slide_lower_reg  <= cfg_data[0];
                CFG_SLIDE_UPPER:  slide_upper_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Direction decode. The user must hold config static while items are in
    // flight, which the block does not enforce; stages 1 and 4 read the registers.
    logic vertical;
    logic falling;
    logic before_slides;
    logic after_slides;

    assign vertical      = (direction_reg == DIR_TOP_BOTTOM) || (direction_reg == DIR_BOTTOM_TOP);
    assign falling       = (direction_reg == DIR_TOP_BOTTOM) || (direction_reg == DIR_LEFT_RIGHT);
    assign before_slides = falling ? slide_upper_reg : slide_lower_reg;
    assign after_slides  = falling ? slide_lower_reg : slide_upper_reg;

    // stage advance chain: a stage moves when empty or when the next one moves
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || result.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixel.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= pixel.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: pick axis, clamp side, multiply side by progress
    logic [SIDE_W-1:0]  side_raw;
    logic [SIDE_W-1:0]  side_next;
    logic [FRAC_W-1:0]  frac;
    logic [PROD_W-1:0]  prod_next;

    assign side_raw  = vertical ? frame_height_reg : frame_width_reg;
    assign side_next = ({{(32-SIDE_W){1'b0}}, side_raw} > MAX_SIDE) ?
                       MAX_SIDE[SIDE_W-1:0] : side_raw;
    assign frac      = falling ? (FRAC_FULL - amount_reg) : amount_reg;
    assign prod_next = PROD_W'(side_next) * PROD_W'(frac);

    logic [PROD_W-1:0]  prod1_reg;
    logic [SIDE_W-1:0]  side1_reg, side2_reg, side3_reg;
    logic [COORD_W-1:0] pos1_reg, pos2_reg, pos3_reg;
    logic [COORD_W-1:0] cross1_reg, cross2_reg, cross3_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            prod1_reg  <= prod_next;
            side1_reg  <= side_next;
            pos1_reg   <= vertical ? pixel.pixel_y : pixel.pixel_x;
            cross1_reg <= vertical ? pixel.pixel_x : pixel.pixel_y;
        end
        if (adv2)
        begin
            side2_reg  <= side1_reg;
            pos2_reg   <= pos1_reg;
            cross2_reg <= cross1_reg;
        end
        if (adv3)
        begin
            side3_reg  <= side2_reg;
            pos3_reg   <= pos2_reg;
            cross3_reg <= cross2_reg;
        end
    end

    // stages 2 and 3: bound = floor(prod / 255)
    stm_div_ctrl_t     div_ctrl;
    logic [SIDE_W-1:0] bound3;

    assign div_ctrl.load_mul = adv2;
    assign div_ctrl.load_fix = adv3;

    stm_div255 u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (prod1_reg),
        .quotient (bound3)
    );

    // stage 4: compare against the bound and apply the slide offset
    logic               before_bound;
    logic [COORD_W-1:0] gap;
    logic [COORD_W-1:0] src;

    assign before_bound = {1'b0, pos3_reg} < bound3;
    assign gap          = COORD_W'(side3_reg - bound3);

    always_comb
    begin
        if (before_bound)
        begin
            src = pos3_reg + (before_slides ? gap : '0);
        end
        else
        begin
            src = pos3_reg - (after_slides ? bound3[COORD_W-1:0] : '0);
        end
    end

    logic               from_second_reg;
    logic [COORD_W-1:0] source_x_reg;
    logic [COORD_W-1:0] source_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            from_second_reg <= before_bound ? !falling : falling;
            source_x_reg    <= vertical ? cross3_reg : src;
            source_y_reg    <= vertical ? src : cross3_reg;
        end
    end

    assign result.valid       = v4_reg;
    assign result.from_second = from_second_reg;
    assign result.source_x    = source_x_reg;
    assign result.source_y    = source_y_reg;

    // an empty front stage always takes an item
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> pixel.ready)
        else $error("front stage empty but not ready");

    // an accepted item occupies the front stage next cycle
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> v1_reg)
        else $error("accepted item lost at front stage");

    // a blocked stage 3 keeps its item and its bound
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv3) |=> (v3_reg && $stable(bound3) && $stable(pos3_reg)))
        else $error("stage 3 changed while stalled");

    // the bound never passes the side
    a_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (bound3 <= side3_reg))
        else $error("bound above frame side");

endmodule
